// ----- hdl/rsi_pkg.sv -----
// Package: shared types of the ray/sphere intersection pipeline.
`default_nettype none
package rsi_pkg;

  // Control bits that ride along each pipeline stage
  typedef struct packed {
    logic valid;
    logic neg;
  } rsi_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/rsi_if.sv -----
// Interfaces: ray/sphere input channel and intersection result channel.
`default_nettype none
interface rsi_in_if
  import rsi_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] origin_x;
  logic signed [WORD_BITS-1:0] origin_y;
  logic signed [WORD_BITS-1:0] origin_z;
  logic signed [FRAC_BITS+1:0] dir_x;
  logic signed [FRAC_BITS+1:0] dir_y;
  logic signed [FRAC_BITS+1:0] dir_z;
  logic signed [WORD_BITS-1:0] center_x;
  logic signed [WORD_BITS-1:0] center_y;
  logic signed [WORD_BITS-1:0] center_z;
  logic        [WORD_BITS-2:0] sphere_radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, sphere_radius, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface rsi_out_if
  import rsi_pkg::*;
#(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WORD_BITS-2:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface
`default_nettype wire

// ----- hdl/ray_sphere_intersection_core.sv -----
// Top level: pipelined ray/sphere intersection (unit direction, Q16.16 fixed point).
// Path: offsets, products, b and c, b*b halves, disc, SW root stages, result (SW = 54 at defaults).
// Throughput: one word per cycle unless stalled; one root bit per sqrt stage sets depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none
module ray_sphere_intersection_core
  import rsi_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  rsi_in_if.sink   in_i,
  rsi_out_if.source out_o
);

  localparam int OW    = WORD_BITS + 1;          // origin - center
  localparam int DW    = FRAC_BITS + 2;          // direction
  localparam int RADW  = WORD_BITS - 1;          // radius
  localparam int BW    = OW + DW + 2;            // b, Q.2F
  localparam int CW    = 2 * OW + 3;             // c, Q.2F
  localparam int H     = (BW + 1) / 2;           // low half of |b|
  localparam int HW    = BW - H;                 // high half of |b|
  localparam int DA    = 2 * BW + 1;
  localparam int DB    = CW + 2 * FRAC_BITS;
  localparam int DISCW = ((DA > DB) ? DA : DB) + 1;  // discriminant, Q.4F
  localparam int SW    = (DISCW + 1) / 2;        // square root bits
  localparam int RW    = SW + 3;                 // sqrt remainder
  localparam int TW    = ((BW > SW) ? BW : SW) + 2;  // roots
  localparam int DSTW  = WORD_BITS - 1;

  // Global advance: the pipeline moves unless the result word is stuck
  logic en;
  logic vout_q;
  assign en         = !vout_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- stage 1: offsets ----------------
  logic                   v1_q;
  logic signed [OW-1:0]   ocx_q, ocy_q, ocz_q;
  logic signed [DW-1:0]   dx_q, dy_q, dz_q;
  logic        [RADW-1:0] rad_q;

  // ---------------- stage 2: products ----------------
  logic                       v2_q;
  logic signed [OW+DW-1:0]    pdx_q, pdy_q, pdz_q;
  logic signed [2*OW-1:0]     sqx_q, sqy_q, sqz_q;
  logic        [2*RADW-1:0]   rr_q;

  // ---------------- stage 3: b and c ----------------
  logic                 v3_q;
  logic signed [BW-1:0] b3_q;
  logic signed [CW-1:0] c3_q;

  // ---------------- stage 4: partial products of b*b ----------------
  logic                 v4_q;
  logic signed [BW-1:0] b4_q;
  logic signed [CW-1:0] c4_q;
  logic [2*HW-1:0]      hh_q;
  logic [HW+H-1:0]      hl_q;
  logic [2*H-1:0]       ll_q;

  // ---------------- sqrt pipeline, index 0 loaded by stage 5 ----------------
  rsi_ctl_t             ctl_q  [SW+1];
  logic [2*SW-1:0]      dsh_q  [SW+1];
  logic [RW-1:0]        rem_q  [SW+1];
  logic [SW-1:0]        root_q [SW+1];
  logic signed [BW-1:0] bs_q   [SW+1];

  logic hit_q;
  logic [DSTW-1:0] dist_q;

  // stage combinational terms
  logic signed [BW-1:0]    b_d;
  logic signed [CW-1:0]    c_d;
  logic        [BW-1:0]    babs;
  logic        [DISCW-1:0] bb;
  logic signed [DISCW-1:0] disc_d;

  assign b_d = BW'(pdx_q) + BW'(pdy_q) + BW'(pdz_q);
  assign c_d = CW'(sqx_q) + CW'(sqy_q) + CW'(sqz_q) - CW'($signed({1'b0, rr_q}));
  assign babs = b3_q[BW-1] ? BW'(-b3_q) : BW'(b3_q);
  assign bb = (DISCW'(hh_q) << (2 * H)) + (DISCW'(hl_q) << (H + 1)) + DISCW'(ll_q);
  assign disc_d = $signed(bb) - ($signed(DISCW'(c4_q)) <<< (2 * FRAC_BITS));

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ctl_q[0] <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ctl_q[0] <= '{valid: v4_q, neg: disc_d[DISCW-1]};
      vout_q <= ctl_q[SW].valid;
    end
  end

  // data path, stages 1 to 5
  always_ff @(posedge clk_i) begin
    if (en) begin
      ocx_q <= OW'(in_i.origin_x) - OW'(in_i.center_x);
      ocy_q <= OW'(in_i.origin_y) - OW'(in_i.center_y);
      ocz_q <= OW'(in_i.origin_z) - OW'(in_i.center_z);
      dx_q  <= in_i.dir_x;
      dy_q  <= in_i.dir_y;
      dz_q  <= in_i.dir_z;
      rad_q <= in_i.sphere_radius;

      pdx_q <= ocx_q * dx_q;
      pdy_q <= ocy_q * dy_q;
      pdz_q <= ocz_q * dz_q;
      sqx_q <= ocx_q * ocx_q;
      sqy_q <= ocy_q * ocy_q;
      sqz_q <= ocz_q * ocz_q;
      rr_q  <= rad_q * rad_q;

      b3_q <= b_d;
      c3_q <= c_d;

      // |b| squared from halves: hi*hi, hi*lo, lo*lo
      b4_q <= b3_q;
      c4_q <= c3_q;
      hh_q <= babs[BW-1:H] * babs[BW-1:H];
      hl_q <= babs[BW-1:H] * babs[H-1:0];
      ll_q <= babs[H-1:0] * babs[H-1:0];

      dsh_q[0]     <= (2 * SW)'($unsigned(disc_d));
      rem_q[0]     <= '0;
      root_q[0]    <= '0;
      bs_q[0]      <= b4_q;
    end
  end

  // Restoring square root, one root bit per stage
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] r2, trial;
    logic          ge;
    assign r2    = {rem_q[k][RW-3:0], dsh_q[k][2*SW-1:2*SW-2]};
    assign trial = RW'({root_q[k], 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsh_q[k+1]     <= dsh_q[k] << 2;
        rem_q[k+1]     <= ge ? (r2 - trial) : r2;
        root_q[k+1]    <= {root_q[k][SW-2:0], ge};
        bs_q[k+1]      <= bs_q[k];
      end
    end
  end

  // Root selection: miss on a negative discriminant, else near root if >= 0, else far root if >= 0, else miss
  logic signed [TW-1:0] nb, sq, t0, t1, tsel, dsh_t;
  logic                 hit_d;
  logic [DSTW-1:0]      dist_d;

  assign nb    = -TW'(bs_q[SW]);
  assign sq    = $signed(TW'(root_q[SW]));
  assign t0    = nb - sq;
  assign t1    = nb + sq;
  assign tsel  = !t0[TW-1] ? t0 : t1;
  assign dsh_t = tsel >>> FRAC_BITS;

  always_comb begin
    hit_d  = !ctl_q[SW].neg && (!t0[TW-1] || !t1[TW-1]);
    dist_d = '0;
    if (hit_d) begin
      // saturate anything beyond the distance field
      dist_d = (|dsh_t[TW-1:DSTW]) ? {DSTW{1'b1}} : dsh_t[DSTW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_o.valid    = vout_q;
  assign out_o.hit      = hit_q;
  assign out_o.distance = dist_q;

  // ---------------- assertions ----------------
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> out_o.distance == '0)
    else $error("miss word carries nonzero distance");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result stalled");

  a_neg_disc_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[SW].valid && ctl_q[SW].neg && en |=> !out_o.hit)
    else $error("negative discriminant reported as hit");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the ray/sphere intersection core: scoreboard, stimulus and result checking.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIR_BITS  = FRAC_BITS + 2;
  localparam int RAD_BITS  = WORD_BITS - 1;
  localparam int N_RANDOM  = 950;
  // Give the drain a healthy margin on top of the core pipeline depth.
  localparam int DRAIN_CYCLES = 200;
  localparam logic [RAD_BITS-1:0] DIST_MAX = '1;
  localparam logic signed [DIR_BITS-1:0] ONE = 18'sd65536;

  typedef logic signed [255:0] wide_t;

  // One ray/sphere pair as carried by the input word
  typedef struct {
    logic signed [WORD_BITS-1:0] ox, oy, oz;
    logic signed [DIR_BITS-1:0]  dx, dy, dz;
    logic signed [WORD_BITS-1:0] cx, cy, cz;
    logic        [RAD_BITS-1:0]  rad;
  } ray_pair_t;

  typedef struct {
    logic                hit;
    logic [RAD_BITS-1:0] distance;
  } hit_rec_t;

  logic clk_i;
  logic rst_ni;

  rsi_in_if  #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) ray_bus ();
  rsi_out_if #(.WORD_BITS(WORD_BITS))                          hit_bus ();

  ray_sphere_intersection_core #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ray_bus.sink),
    .out_o (hit_bus.source)
  );

  // Scoreboard: predicts each accepted pair, checks results in order.
  class hit_scoreboard;
    hit_rec_t pending[$];
    int       errors;
    int       n_hits;
    int       n_miss;
    int       n_sat;
    int       n_checked;

    function new();
      errors = 0; n_hits = 0; n_miss = 0; n_sat = 0; n_checked = 0;
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      errors++;
    endtask

    // Floor integer square root; disc stays well below 2^128.
    function logic [63:0] isqrt(wide_t v);
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] sq;
      root = '0;
      for (int bitpos = 63; bitpos >= 0; bitpos--) begin
        trial = root | (64'd1 << bitpos);
        sq = 128'(trial) * 128'(trial);
        if (wide_t'(sq) <= v) root = trial;
      end
      return root;
    endfunction

    function hit_rec_t solve_pair(ray_pair_t p);
      wide_t    ocx, ocy, ocz, bdot, coff, disc, root, near_t, far_t, pick, dq;
      hit_rec_t r;
      ocx = wide_t'(p.ox) - wide_t'(p.cx);
      ocy = wide_t'(p.oy) - wide_t'(p.cy);
      ocz = wide_t'(p.oz) - wide_t'(p.cz);
      bdot = ocx * wide_t'(p.dx) + ocy * wide_t'(p.dy) + ocz * wide_t'(p.dz);
      coff = ocx * ocx + ocy * ocy + ocz * ocz - wide_t'({1'b0, p.rad}) * wide_t'({1'b0, p.rad});
      disc = bdot * bdot - (coff <<< (2 * FRAC_BITS));
      r.hit = 1'b0;
      r.distance = '0;
      if (disc < 0) return r;
      root   = wide_t'({1'b0, isqrt(disc)});
      near_t = -bdot - root;
      far_t  = -bdot + root;
      if (near_t >= 0) pick = near_t;
      else if (far_t >= 0) pick = far_t;
      else return r;
      dq = pick >>> FRAC_BITS;
      r.hit = 1'b1;
      r.distance = (dq > wide_t'({1'b0, DIST_MAX})) ? DIST_MAX : dq[RAD_BITS-1:0];
      return r;
    endfunction

    function void note_ray(ray_pair_t p);
      pending.push_back(solve_pair(p));
    endfunction

    task check_result(logic hit, logic [RAD_BITS-1:0] distance);
      hit_rec_t want;
      n_checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result hit=%0b distance=%0h", hit, distance));
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit %0b, expected %0b", hit, want.hit));
      if (distance !== want.distance)
        report($sformatf("distance %0h, expected %0h", distance, want.distance));
      if (want.hit) n_hits++;
      else n_miss++;
      if (want.hit && want.distance == DIST_MAX) n_sat++;
    endtask
  endclass

  hit_scoreboard sb;
  int            n_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Timeout: results did not drain");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: ready follows a pattern whose mode is redrawn at random as the cycle counter wraps:
  // always ready, coin toss, mostly stalled, or long periodic stalls.
  int unsigned rx_cycle;
  int unsigned rx_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_bus.ready <= 1'b0;
      rx_cycle      <= 0;
      rx_mode       <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: hit_bus.ready <= 1'b1;
        1: hit_bus.ready <= $urandom_range(0, 1);
        2: hit_bus.ready <= ($urandom_range(0, 3) == 0);
        default: hit_bus.ready <= (rx_cycle % 16) < 11;
      endcase
    end
  end

  // Result monitor: a word moves when valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && hit_bus.valid === 1'b1 && hit_bus.ready === 1'b1)
      sb.check_result(hit_bus.hit, hit_bus.distance);
  end

  function automatic ray_pair_t mk_pair(int ox, int oy, int oz,
                                        int dx, int dy, int dz,
                                        int cx, int cy, int cz, int rad);
    ray_pair_t p;
    p.ox = ox; p.oy = oy; p.oz = oz;
    p.dx = dx[DIR_BITS-1:0]; p.dy = dy[DIR_BITS-1:0]; p.dz = dz[DIR_BITS-1:0];
    p.cx = cx; p.cy = cy; p.cz = cz;
    p.rad = rad[RAD_BITS-1:0];
    return p;
  endfunction

  function automatic logic signed [DIR_BITS-1:0] rand_dir_comp(int unsigned mode);
    case (mode)
      0: return 18'($urandom);                                  // any pattern
      1: return 18'($signed($urandom_range(0, 92682)) - 46341); // near unit scale
      default: return 18'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // Mostly geometric rays near a sphere with random content; the rest is raw noise.
  function automatic ray_pair_t rand_pair();
    ray_pair_t   p;
    int unsigned kind, axis, dmode, span;
    logic signed [DIR_BITS-1:0] sgn;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
      p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
      p.dx = 18'($urandom); p.dy = 18'($urandom); p.dz = 18'($urandom);
      p.rad = 31'($urandom);
      return p;
    end
    span = 1 << $urandom_range(8, 30);
    p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
    p.ox = p.cx + $signed($urandom_range(0, span - 1)) - $signed(span / 2);
    p.oy = p.cy + $signed($urandom_range(0, span - 1)) - $signed(span / 2);
    p.oz = p.cz + $signed($urandom_range(0, span - 1)) - $signed(span / 2);
    dmode = $urandom_range(0, 3);
    if (dmode == 3) begin
      axis = $urandom_range(0, 2);
      sgn  = $urandom_range(0, 1) ? ONE : -ONE;
      p.dx = (axis == 0) ? sgn : '0;
      p.dy = (axis == 1) ? sgn : '0;
      p.dz = (axis == 2) ? sgn : '0;
    end else begin
      p.dx = rand_dir_comp(dmode);
      p.dy = rand_dir_comp(dmode);
      p.dz = rand_dir_comp(dmode);
    end
    p.rad = (kind < 8) ? 31'($urandom_range(0, span)) : 31'($urandom);
    return p;
  endfunction

  // Puts one pair on the input channel and holds it until accepted.
  task automatic send_pair(ray_pair_t p);
    ray_bus.valid         <= 1'b1;
    ray_bus.origin_x      <= p.ox;
    ray_bus.origin_y      <= p.oy;
    ray_bus.origin_z      <= p.oz;
    ray_bus.dir_x         <= p.dx;
    ray_bus.dir_y         <= p.dy;
    ray_bus.dir_z         <= p.dz;
    ray_bus.center_x      <= p.cx;
    ray_bus.center_y      <= p.cy;
    ray_bus.center_z      <= p.cz;
    ray_bus.sphere_radius <= p.rad;
    @(posedge clk_i);
    while (ray_bus.ready !== 1'b1) @(posedge clk_i);
    sb.note_ray(p);
    n_sent++;
  endtask

  // Bursts of random length with random gaps; valid drops only in a gap.
  task automatic stream_pairs(ray_pair_t list[$]);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 40);
    foreach (list[i]) begin
      send_pair(list[i]);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          ray_bus.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end
    ray_bus.valid <= 1'b0;
  endtask

  initial begin
    ray_pair_t directed[$];
    ray_pair_t randoms[$];
    sb     = new();
    n_sent = 0;
    rst_ni = 1'b0;
    ray_bus.valid         = 1'b0;
    ray_bus.origin_x      = '0;
    ray_bus.origin_y      = '0;
    ray_bus.origin_z      = '0;
    ray_bus.dir_x         = '0;
    ray_bus.dir_y         = '0;
    ray_bus.dir_z         = '0;
    ray_bus.center_x      = '0;
    ray_bus.center_y      = '0;
    ray_bus.center_z      = '0;
    ray_bus.sphere_radius = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain hit ahead, origin inside, sphere behind, side miss
    directed.push_back(mk_pair(0, 0, 0, 0, 0, 65536, 0, 0, 655360, 65536));
    directed.push_back(mk_pair(0, 0, 0, 65536, 0, 0, 65536, 0, 0, 327680));
    directed.push_back(mk_pair(0, 0, 0, 0, 0, 65536, 0, 0, -655360, 65536));
    directed.push_back(mk_pair(0, 0, 0, 0, 0, 65536, 655360, 0, 655360, 65536));
    // Zero radius: on the ray, and just off it
    directed.push_back(mk_pair(0, 0, 0, 0, 65536, 0, 0, 196608, 0, 0));
    directed.push_back(mk_pair(0, 0, 0, 0, 65536, 0, 1, 196608, 0, 0));
    // Tangent ray
    directed.push_back(mk_pair(0, 65536, 0, 0, 0, 65536, 0, 0, 655360, 65536));
    // Far hit that saturates the distance, and a large sphere behind the ray
    directed.push_back(mk_pair(32'h80000000, 0, 0, 65536, 0, 0,
                               32'h7fffffff, 0, 0, 65536));
    directed.push_back(mk_pair(32'h80000000, 32'h80000000, 32'h80000000,
                               -65536, -65536, -65536,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    // Field extremes, non-unit directions beyond +-1.0
    directed.push_back(mk_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               18'h1ffff, 18'h1ffff, 18'h1ffff,
                               32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    directed.push_back(mk_pair(32'h80000000, 32'h7fffffff, 0,
                               18'h20000, 18'h20000, 18'h20000,
                               32'h7fffffff, 32'h80000000, 0, 0));
    directed.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff));
    directed.push_back(mk_pair(-1, -1, -1, -1, -1, -1, 0, 0, 0, 1));
    directed.push_back(mk_pair(0, 0, 0, 46341, 46341, 0, 655360, 655360, 0, 131072));
    stream_pairs(directed);

    for (int i = 0; i < N_RANDOM; i++) randoms.push_back(rand_pair());
    stream_pairs(randoms);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ray/sphere pairs, %0d results checked", n_sent, sb.n_checked);
    $display("Hits %0d (saturated %0d), misses %0d", sb.n_hits, sb.n_sat, sb.n_miss);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- ray_sphere_intersection_core.f -----
hdl/rsi_pkg.sv
hdl/rsi_if.sv
hdl/ray_sphere_intersection_core.sv
tb/testbench.sv
